// ----- design/tsw_pkg.sv -----
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants for the TCP sender window block
// Command codes, queue sizing, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tsw_pkg;
    localparam int MaxPayload  = 1024;
    localparam int QueueDepth  = 64;
    localparam int MaxResults  = 64;
    localparam int QAW         = $clog2(QueueDepth);
    localparam int QCW         = $clog2(QueueDepth + 1);
    localparam int RCW         = $clog2(MaxResults + 1);
    localparam int EntryW      = 64 + 11 + 2;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_ISN = 1'b0,
        CFG_RTO = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] bytes_ready;
        logic        stream_closed;
        logic        stream_error;
        logic        ack_present;
        logic [31:0] ack_number;
        logic [15:0] peer_window;
        logic        peer_reset;
        logic [15:0] elapsed_ms;
    } in_beat_t;

    typedef struct packed {
        logic        segment_valid;
        logic [31:0] seqno;
        logic        syn_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [10:0] payload_len;
        logic        is_retransmit;
        logic [16:0] in_flight;
        logic [7:0]  retransmit_count;
        logic        last;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic push_init;  // compute window for push
        logic push_step;  // build one segment or status beat
        logic ack_upd;    // window, rst latch, ackno accept
        logic ack_rd;     // never asserted; the RAM reads the head entry continuously
        logic ack_pop;    // evaluate head entry
        logic ack_fin;    // empty queue cleanup
        logic tick_upd;   // advance timer
        logic tick_fire;  // retransmit bookkeeping
        logic status;     // emit status beat
        logic emit_retx;  // emit retransmit beat
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       push_more;  // another segment may be built
        logic       push_done;  // push has ended, at init or by a push step
        logic       push_any;   // at least one beat emitted
        logic       head_retire;
        logic       queue_empty;
        logic       timer_running;
        logic       tick_timeout;
    } dp_stat_t;
endpackage
`default_nettype wire

// ----- design/tsw_if.sv -----
// ----------------------------------------------------------------------------
// tsw_if: valid/ready channel carrying one beat of payload
// ----------------------------------------------------------------------------
`default_nettype none
interface tsw_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/tcp_sender_window_retransmit.sv -----
// One command is taken at a time; a push builds its next segment beat only after
// the previous beat has been taken. Pace is set by the sequencer, the output
// handshake and the registered read of the entry RAM.
// Reset (rst_n, async, active low) clears all control state; the entry RAM
// needs no clearing, as only queued entries are read.
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit: TCP sender window and retransmission control
// Emits segment descriptors for push, ack, tick and query commands.
// ----------------------------------------------------------------------------
`default_nettype none
module tcp_sender_window_retransmit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    tsw_if.sink              in_ch,
    tsw_if.source            out_ch
);
    import tsw_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;
    out_beat_t beat;

    tsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_last  (beat.last),
        .stat      (stat),
        .ctl       (ctl)
    );

    tsw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_ch.data),
        .ctl       (ctl),
        .stat      (stat),
        .beat      (beat)
    );

    assign out_ch.data = beat;

`ifndef SYNTHESIS
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.push_step, ctl.emit_retx, ctl.status}))
        else $error("multiple beat producers");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready || out_ch.data.last)
        else $error("input accepted while beat pending");
    a_retx_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_retx |-> !stat.queue_empty)
        else $error("retransmit with empty queue");
`endif
endmodule
`default_nettype wire

// ----- design/tsw_ram.sv -----
// ----------------------------------------------------------------------------
// tsw_ram: generic single-write, single-read RAM with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module tsw_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/tsw_datapath.sv -----
// ----------------------------------------------------------------------------
// tsw_datapath: sender state, entry queue and segment arithmetic
// Executes one controller command per cycle and builds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tsw_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire tsw_pkg::in_beat_t  in_beat,
    input  wire tsw_pkg::ctl_cmd_t  ctl,
    output tsw_pkg::dp_stat_t       stat,
    output tsw_pkg::out_beat_t      beat
);
    import tsw_pkg::*;

    in_beat_t    in_reg;
    logic [31:0] isn_reg;
    logic [15:0] rto_init_reg;
    logic [QAW-1:0] head_reg;
    logic [QCW-1:0] count_reg;
    logic [63:0] next_reg, acked_reg, index_reg;
    logic [16:0] win_reg;
    logic [15:0] avail_reg;
    logic [15:0] window_reg;
    logic [31:0] rto_reg, elapsed_reg;
    logic        running_reg, fin_done_reg, err_reg;
    logic [7:0]  retries_reg;
    logic [16:0] outst_reg;
    logic [RCW-1:0] nres_reg;
    logic        done_reg, any_reg;
    logic        err_now;

    // entry RAM
    logic             ram_we;
    logic [QAW-1:0]   ram_waddr;
    logic [EntryW-1:0] ram_wdata, ram_rdata;
    logic [63:0]      e_start;
    logic [10:0]      e_len;
    logic [1:0]       e_flags;
    logic [11:0]      e_seqlen;

    tsw_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign e_start  = ram_rdata[EntryW-1 -: 64];
    assign e_len    = ram_rdata[12:2];
    assign e_flags  = ram_rdata[1:0];
    assign e_seqlen = {1'b0, e_len} + {11'd0, e_flags[0]} + {11'd0, e_flags[1]};
    assign err_now  = in_reg.stream_error | err_reg;

    // push step arithmetic
    logic        s_syn, s_fin, s_stop;
    logic [16:0] s_win1, s_len17;
    logic [10:0] s_len;
    logic [15:0] s_avail;
    logic [11:0] s_seqlen;
    always_comb
    begin
        s_syn  = (index_reg == 64'd0);
        s_win1 = win_reg - {16'd0, s_syn};
        s_len17 = (s_win1 < 17'(MaxPayload)) ? s_win1 : 17'(MaxPayload);
        if ({1'b0, avail_reg} < s_len17)
        begin
            s_len17 = {1'b0, avail_reg};
        end
        s_len   = s_len17[10:0];
        s_avail = avail_reg - 16'(s_len);
        s_fin   = (s_win1 > s_len17) && in_reg.stream_closed && (s_avail == 16'd0)
                  && !fin_done_reg;
        s_seqlen = {11'd0, s_syn} + {1'b0, s_len} + {11'd0, s_fin};
        s_stop  = (s_seqlen == 12'd0);
    end

    // ack unwrap
    logic [63:0] u_cand, u_abs;
    logic [31:0] u_off;
    always_comb
    begin
        u_off  = in_reg.ack_number - isn_reg;
        u_cand = {acked_reg[63:32], u_off};
        u_abs  = u_cand;
        if (u_cand > acked_reg && (u_cand - acked_reg) > 64'h8000_0000
            && u_cand[63:32] != 32'd0)
        begin
            u_abs = u_cand - 64'h1_0000_0000;
        end
        else if (u_cand < acked_reg && (acked_reg - u_cand) > 64'h8000_0000)
        begin
            u_abs = u_cand + 64'h1_0000_0000;
        end
    end

    logic [32:0] t_sum;
    assign t_sum = {1'b0, elapsed_reg} + {17'd0, in_reg.elapsed_ms};

    logic [63:0] limit;
    logic [15:0] win_eff;
    assign win_eff = (window_reg == 16'd0) ? 16'd1 : window_reg;
    assign limit   = acked_reg + {48'd0, win_eff};

    // next step builds a segment only if window, stream bytes, result slots and queue room remain and no FIN was sent
    logic cont;
    assign cont = (s_win1 - s_len17 - {16'd0, s_fin}) != 17'd0 && !s_fin
                  && (s_avail != 16'd0)
                  && (nres_reg + 1'b1) < RCW'(MaxResults)
                  && (count_reg + 1'b1) < QCW'(QueueDepth);

    assign ram_we    = ctl.push_step && !err_now && !s_stop;
    assign ram_waddr = head_reg + count_reg[QAW-1:0];
    assign ram_wdata = {index_reg, s_len, s_fin, s_syn};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isn_reg      <= '0;
            rto_init_reg <= 16'd1000;
            head_reg     <= '0;
            count_reg    <= '0;
            next_reg     <= '0;
            acked_reg    <= '0;
            window_reg   <= 16'd1;
            rto_reg      <= 32'd1000;
            elapsed_reg  <= '0;
            running_reg  <= 1'b0;
            fin_done_reg <= 1'b0;
            retries_reg  <= '0;
            outst_reg    <= '0;
            err_reg      <= 1'b0;
            done_reg     <= 1'b0;
            any_reg      <= 1'b0;
            nres_reg     <= '0;
            beat         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ISN)
                begin
                    isn_reg <= cfg_data;
                end
                else
                begin
                    rto_init_reg <= cfg_data[15:0];
                    rto_reg      <= {16'd0, cfg_data[15:0]};
                end
            end
            if (ctl.push_init)
            begin
                index_reg <= next_reg;
                avail_reg <= in_reg.bytes_ready;
                win_reg   <= (limit > next_reg) ? 17'(limit - next_reg) : 17'd0;
                nres_reg  <= '0;
                any_reg   <= 1'b0;
                done_reg  <= !(limit > next_reg) || fin_done_reg
                             || count_reg >= QCW'(QueueDepth);
            end
            if (ctl.push_step)
            begin
                beat.seqno            <= index_reg[31:0] + isn_reg;
                beat.syn_flag         <= s_syn;
                beat.fin_flag         <= s_fin;
                beat.payload_len      <= s_len;
                beat.is_retransmit    <= 1'b0;
                beat.retransmit_count <= retries_reg;
                if (s_syn && err_now)
                begin
                    running_reg <= 1'b1;
                end
                if (s_fin)
                begin
                    fin_done_reg <= 1'b1;
                end
                if (err_now)
                begin
                    beat.segment_valid <= 1'b1;
                    beat.rst_flag      <= 1'b1;
                    beat.in_flight     <= outst_reg;
                    beat.last          <= 1'b1;
                    next_reg           <= index_reg;
                    done_reg           <= 1'b1;
                    any_reg            <= 1'b1;
                end
                else if (s_stop)
                begin
                    // nothing to send: status beat at next_position
                    beat.segment_valid <= 1'b0;
                    beat.rst_flag      <= 1'b0;
                    beat.in_flight     <= outst_reg;
                    beat.last          <= 1'b1;
                    next_reg           <= index_reg;
                    done_reg           <= 1'b1;
                    any_reg            <= 1'b1;
                end
                else
                begin
                    beat.segment_valid <= 1'b1;
                    beat.rst_flag      <= 1'b0;
                    beat.in_flight     <= outst_reg + 17'(s_seqlen);
                    beat.last          <= !cont;
                    count_reg          <= count_reg + 1'b1;
                    outst_reg          <= outst_reg + 17'(s_seqlen);
                    running_reg        <= 1'b1;
                    index_reg          <= index_reg + 64'(s_seqlen);
                    next_reg           <= index_reg + 64'(s_seqlen);
                    win_reg            <= s_win1 - s_len17 - {16'd0, s_fin};
                    avail_reg          <= s_avail;
                    nres_reg           <= nres_reg + 1'b1;
                    any_reg            <= 1'b1;
                    done_reg           <= !cont;
                end
            end
            if (ctl.ack_upd)
            begin
                window_reg <= in_reg.peer_window;
                if (in_reg.peer_reset)
                begin
                    err_reg <= 1'b1;
                end
                if (in_reg.ack_present && u_abs > acked_reg && u_abs <= next_reg)
                begin
                    acked_reg   <= u_abs;
                    rto_reg     <= {16'd0, rto_init_reg};
                    elapsed_reg <= '0;
                    retries_reg <= '0;
                end
            end
            if (ctl.ack_pop && stat.head_retire)
            begin
                outst_reg <= outst_reg - 17'(e_seqlen);
                head_reg  <= head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (ctl.ack_fin && in_reg.ack_present && count_reg == '0)
            begin
                running_reg <= 1'b0;
                rto_reg     <= {16'd0, rto_init_reg};
                elapsed_reg <= '0;
                retries_reg <= '0;
            end
            if (ctl.tick_upd)
            begin
                elapsed_reg <= t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
            end
            if (ctl.tick_fire)
            begin
                if (window_reg != 16'd0)
                begin
                    rto_reg <= rto_reg[31] ? 32'hFFFF_FFFF : {rto_reg[30:0], 1'b0};
                    if (retries_reg != 8'hFF)
                    begin
                        retries_reg <= retries_reg + 1'b1;
                    end
                end
                elapsed_reg <= '0;
            end
            if (ctl.emit_retx)
            begin
                beat.segment_valid    <= 1'b1;
                beat.seqno            <= e_start[31:0] + isn_reg;
                beat.syn_flag         <= e_flags[0];
                beat.fin_flag         <= e_flags[1];
                beat.rst_flag         <= 1'b0;
                beat.payload_len      <= e_len;
                beat.is_retransmit    <= 1'b1;
                beat.in_flight        <= outst_reg;
                beat.retransmit_count <= retries_reg;
                beat.last             <= 1'b1;
            end
            if (ctl.status)
            begin
                beat.segment_valid    <= 1'b0;
                beat.seqno            <= next_reg[31:0] + isn_reg;
                beat.syn_flag         <= 1'b0;
                beat.fin_flag         <= 1'b0;
                beat.rst_flag         <= (in_reg.cmd == CMD_QUERY) && err_now;
                beat.payload_len      <= '0;
                beat.is_retransmit    <= 1'b0;
                beat.in_flight        <= outst_reg;
                beat.retransmit_count <= retries_reg;
                beat.last             <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= in_beat;
        end
    end

    always_comb
    begin
        stat.cmd           = in_reg.cmd;
        stat.push_more     = !done_reg;
        stat.push_done     = done_reg;
        stat.push_any      = any_reg;
        stat.head_retire   = (count_reg != '0) && (e_start + 64'(e_seqlen) <= acked_reg);
        stat.queue_empty   = (count_reg == '0);
        stat.timer_running = running_reg;
        stat.tick_timeout  = (elapsed_reg >= rto_reg) && (count_reg != '0);
    end
endmodule
`default_nettype wire

// ----- design/tsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsw_ctrl: command sequencer and output handshake
// Walks each command through datapath steps; holds each beat until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module tsw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic              out_last,
    input  wire tsw_pkg::dp_stat_t stat,
    output tsw_pkg::ctl_cmd_t      ctl
);
    import tsw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PUSH, S_ACK_RD, S_ACK_WAIT, S_ACK_POP, S_ACK_FIN,
        S_TICK, S_TICK_RD, S_TICK_WAIT, S_RETX, S_STATUS, S_OUT
    } state_t;

    state_t state_reg;
    logic   ov_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        ctl = '0;
        ctl.load = in_valid && in_ready;
        unique case (state_reg)
            S_DECODE:
            begin
                ctl.push_init = (stat.cmd == CMD_PUSH);
                ctl.ack_upd   = (stat.cmd == CMD_ACK);
                ctl.tick_upd  = (stat.cmd == CMD_TICK) && stat.timer_running;
            end
            S_PUSH:      ctl.push_step = !ov_reg && stat.push_more;
            S_ACK_POP:   ctl.ack_pop   = 1'b1;
            S_ACK_FIN:   ctl.ack_fin   = 1'b1;
            S_TICK_RD:   ctl.tick_fire = 1'b1;
            S_RETX:      ctl.emit_retx = 1'b1;
            S_STATUS:    ctl.status    = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                    priority case (stat.cmd)
                        CMD_PUSH:  state_reg <= S_PUSH;
                        CMD_ACK:   state_reg <= S_ACK_RD;
                        CMD_TICK:  state_reg <= stat.timer_running ? S_TICK : S_STATUS;
                        default:   state_reg <= S_STATUS;
                    endcase
                S_PUSH:
                    if (!ov_reg || out_ready)
                    begin
                        if (ctl.push_step)
                        begin
                            ov_reg <= 1'b1;
                        end
                        else if (!stat.push_more)
                        begin
                            state_reg <= stat.push_any ? S_OUT : S_STATUS;
                        end
                    end
                S_ACK_RD:   state_reg <= S_ACK_WAIT;
                S_ACK_WAIT: state_reg <= S_ACK_POP;
                S_ACK_POP:  state_reg <= stat.head_retire ? S_ACK_RD : S_ACK_FIN;
                S_ACK_FIN:  state_reg <= S_STATUS;
                S_TICK:     state_reg <= stat.tick_timeout ? S_TICK_RD : S_STATUS;
                S_TICK_RD:  state_reg <= S_TICK_WAIT;
                S_TICK_WAIT: state_reg <= S_RETX;
                S_RETX:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_STATUS:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!ov_reg || (out_ready && out_last))
                    begin
                        state_reg <= S_IDLE;
                    end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tcp_sender_window_retransmit
// A queue-fed driver sends command beats with random gaps. A predictor kept in
// step with the block computes the expected descriptor beats. A monitor with
// random backpressure compares every output beat with the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import tsw_pkg::*;

    localparam int WatchLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    tsw_if #(.payload_t(in_beat_t))  in_ch ();
    tsw_if #(.payload_t(out_beat_t)) out_ch ();

    tcp_sender_window_retransmit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [31:0] isn;
    logic [15:0] rto_init;
    logic [63:0] ent_start [QueueDepth];
    logic [10:0] ent_len [QueueDepth];
    logic [1:0]  ent_flags [QueueDepth];
    int unsigned q_head;
    int unsigned q_count;
    logic [63:0] next_pos;
    logic [63:0] acked_pos;
    logic [15:0] win_held;
    logic [31:0] rto_now;
    logic [31:0] tmr_elapsed;
    bit          tmr_running;
    bit          fin_sent;
    logic [7:0]  retry_cnt;
    logic [16:0] bytes_in_flight;
    bit          err_latched;

    in_beat_t  pending_cmds [$];
    out_beat_t expected_segs [$];
    int        n_errors;
    int        in_gap;
    int        out_gap;
    int        idle_cycles;

    // rough view of positions for ack aiming, refreshed from the predictor
    logic [63:0] acked_shadow;
    logic [63:0] next_shadow;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic add_expected(input out_beat_t b);
        expected_segs = {expected_segs, b};
    endtask

    function automatic logic [31:0] wrap_seq(input logic [63:0] pos);
        return pos[31:0] + isn;
    endfunction

    function automatic logic [63:0] unwrap_ack(input logic [31:0] seq, input logic [63:0] chk);
        logic [63:0] cand;
        logic [63:0] half;
        logic [63:0] full;
        half = 64'd1 << 31;
        full = 64'd1 << 32;
        cand = {chk[63:32], seq - isn};
        if (cand > chk && cand - chk > half && cand >= full)
            cand = cand - full;
        else if (cand < chk && chk - cand > half)
            cand = cand + full;
        return cand;
    endfunction

    function automatic out_beat_t mk_beat(input bit v, input logic [31:0] s, input bit syn,
                                          input bit fin, input bit rst, input logic [10:0] len,
                                          input bit retx);
        out_beat_t b;
        b.segment_valid = v;
        b.seqno = s;
        b.syn_flag = syn;
        b.fin_flag = fin;
        b.rst_flag = rst;
        b.payload_len = len;
        b.is_retransmit = retx;
        b.in_flight = bytes_in_flight;
        b.retransmit_count = retry_cnt;
        b.last = 1'b0;
        return b;
    endfunction

    task automatic push_status(input bit rst);
        out_beat_t b;
        b = mk_beat(0, wrap_seq(next_pos), 0, 0, rst, 0, 0);
        b.last = 1'b1;
        add_expected(b);
    endtask

    task automatic restart_rto();
        rto_now = {16'd0, rto_init};
        tmr_elapsed = 0;
        retry_cnt = 0;
    endtask

    task automatic predict_push(input in_beat_t c);
        logic [63:0] idx;
        logic [63:0] lim;
        int unsigned wn;
        int unsigned avail;
        int unsigned len;
        int unsigned seglen;
        int          n;
        int unsigned slot;
        bit          syn;
        bit          fin;
        bit          err;
        out_beat_t   b;
        idx = next_pos;
        lim = acked_pos + ((win_held == 0) ? 64'd1 : {48'd0, win_held});
        wn = (lim > idx) ? int'(lim - idx) : 0;
        avail = c.bytes_ready;
        err = c.stream_error || err_latched;
        n = 0;
        while (wn > 0) begin
            if (fin_sent || n >= MaxResults || q_count >= QueueDepth) break;
            syn = 0;
            fin = 0;
            if (idx == 0) begin
                syn = 1;
                tmr_running = 1;
                wn--;
            end
            len = (wn < MaxPayload) ? wn : MaxPayload;
            if (avail < len) len = avail;
            avail -= len;
            if (wn > len && c.stream_closed && avail == 0 && !fin_sent) begin
                fin = 1;
                fin_sent = 1;
            end
            wn -= len + fin;
            seglen = syn + len + fin;
            if (err) begin
                next_pos = idx;
                b = mk_beat(1, wrap_seq(idx), syn, fin, 1, len, 0);
                b.last = 1'b1;
                add_expected(b);
                return;
            end
            if (seglen == 0) break;
            slot = (q_head + q_count) % QueueDepth;
            ent_start[slot] = idx;
            ent_len[slot] = len;
            ent_flags[slot] = {fin, syn};
            q_count++;
            bytes_in_flight += seglen;
            tmr_running = 1;
            add_expected(mk_beat(1, wrap_seq(idx), syn, fin, 0, len, 0));
            n++;
            idx += seglen;
            if (fin) break;
        end
        next_pos = idx;
        if (n == 0)
            push_status(0);
        else
            expected_segs[$].last = 1'b1;
    endtask

    task automatic predict_ack(input in_beat_t c);
        logic [63:0] abs_ack;
        int unsigned sl;
        win_held = c.peer_window;
        if (c.peer_reset) err_latched = 1;
        if (c.ack_present) begin
            abs_ack = unwrap_ack(c.ack_number, acked_pos);
            if (abs_ack > acked_pos && abs_ack <= next_pos) begin
                acked_pos = abs_ack;
                restart_rto();
            end
            while (q_count > 0) begin
                sl = ent_len[q_head] + ent_flags[q_head][0] + ent_flags[q_head][1];
                if (ent_start[q_head] + sl > acked_pos) break;
                bytes_in_flight -= sl;
                q_head = (q_head + 1) % QueueDepth;
                q_count--;
            end
            if (q_count == 0) begin
                tmr_running = 0;
                restart_rto();
            end
        end
        push_status(0);
    endtask

    task automatic predict_tick(input in_beat_t c);
        out_beat_t b;
        if (!tmr_running) begin
            push_status(0);
            return;
        end
        if (tmr_elapsed > 32'hFFFF_FFFF - c.elapsed_ms)
            tmr_elapsed = 32'hFFFF_FFFF;
        else
            tmr_elapsed = tmr_elapsed + c.elapsed_ms;
        if (tmr_elapsed < rto_now || q_count == 0) begin
            push_status(0);
            return;
        end
        if (win_held != 0) begin
            rto_now = (rto_now > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto_now * 2;
            if (retry_cnt < 255) retry_cnt++;
        end
        tmr_elapsed = 0;
        b = mk_beat(1, wrap_seq(ent_start[q_head]), ent_flags[q_head][0],
                    ent_flags[q_head][1], 0, ent_len[q_head], 1);
        b.last = 1'b1;
        add_expected(b);
    endtask

    task automatic predict_cmd(input in_beat_t c);
        case (cmd_t'(c.cmd))
            CMD_PUSH:  predict_push(c);
            CMD_ACK:   predict_ack(c);
            CMD_TICK:  predict_tick(c);
            default:   push_status(c.stream_error || err_latched);
        endcase
    endtask

    task automatic reset_predictor();
        isn = 0;
        rto_init = 16'd1000;
        q_head = 0;
        q_count = 0;
        next_pos = 0;
        acked_pos = 0;
        win_held = 1;
        rto_now = 1000;
        tmr_elapsed = 0;
        tmr_running = 0;
        fin_sent = 0;
        retry_cnt = 0;
        bytes_in_flight = 0;
        err_latched = 0;
    endtask

    function automatic in_beat_t mk_cmd(input cmd_t op);
        in_beat_t c;
        c = '0;
        c.cmd = op;
        c.peer_window = 16'($urandom_range(0, 65535));
        c.ack_number = $urandom;
        c.elapsed_ms = 16'($urandom_range(0, 65535));
        c.bytes_ready = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    // ack that lands somewhere in the sent range, sometimes off the edges
    function automatic in_beat_t mk_ack_near(input logic [63:0] lo, input logic [63:0] hi);
        in_beat_t c;
        logic [63:0] span;
        c = mk_cmd(CMD_ACK);
        c.ack_present = ($urandom_range(0, 9) != 0);
        span = hi - lo;
        case ($urandom_range(0, 5))
            0: c.ack_number = wrap_seq(hi);
            1: c.ack_number = wrap_seq(hi + $urandom_range(1, 3));
            2: c.ack_number = $urandom;
            default: c.ack_number = wrap_seq(lo + ((span == 0) ? 0 :
                                         64'($urandom) % (span + 1)));
        endcase
        c.peer_window = ($urandom_range(0, 7) == 0) ? 16'd0 :
                        ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                        16'($urandom_range(1, 6000));
        c.peer_reset = ($urandom_range(0, 40) == 0);
        return c;
    endfunction

    function automatic bit in_gap_idle();
        return !in_ch.valid;
    endfunction

    task automatic wait_drain();
        while (pending_cmds.size() != 0 || expected_segs.size() != 0 || !in_gap_idle())
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ISN)
            isn = val;
        else
        begin
            rto_init = val[15:0];
            rto_now = {16'd0, val[15:0]};
        end
    endtask

    task automatic enqueue(input in_beat_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // random session: pushes, acks, ticks and queries against the current stream
    task automatic random_phase(input int count);
        in_beat_t c;
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    c = mk_cmd(CMD_PUSH);
                    c.bytes_ready = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                                    16'($urandom_range(0, 3000));
                    c.stream_closed = ($urandom_range(0, 5) == 0);
                    c.stream_error = ($urandom_range(0, 30) == 0);
                end
                3, 4, 5: c = mk_ack_near(acked_shadow, next_shadow);
                6, 7: begin
                    c = mk_cmd(CMD_TICK);
                    c.elapsed_ms = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
                                   16'($urandom_range(0, 2500));
                end
                default: begin
                    c = mk_cmd(CMD_QUERY);
                    c.stream_error = $urandom_range(0, 1);
                end
            endcase
            c.stream_closed = c.stream_closed | ($urandom_range(0, 60) == 0);
            enqueue(c);
            // track the stream loosely so acks aim at real positions
            while (pending_cmds.size() > 4) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        acked_shadow <= acked_pos;
        next_shadow <= next_pos;
    end

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            in_gap <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                predict_cmd(in_ch.data);
            if (in_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_cmds[0];
                pending_cmds.delete(0);
                in_gap <= $urandom_range(0, 13);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t exp_b;
        out_beat_t got;
        int        gap_draw;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_segs.size() == 0)
                    report_mismatch("unexpected beat");
                else
                begin
                    exp_b = expected_segs[0];
                    expected_segs.delete(0);
                    if (got.segment_valid !== exp_b.segment_valid)
                        report_mismatch("segment_valid");
                    if (got.seqno !== exp_b.seqno)
                        report_mismatch($sformatf("seqno %h exp %h", got.seqno, exp_b.seqno));
                    if (got.syn_flag !== exp_b.syn_flag) report_mismatch("syn_flag");
                    if (got.fin_flag !== exp_b.fin_flag) report_mismatch("fin_flag");
                    if (got.rst_flag !== exp_b.rst_flag) report_mismatch("rst_flag");
                    if (got.payload_len !== exp_b.payload_len)
                        report_mismatch($sformatf("payload_len %0d exp %0d",
                                                  got.payload_len, exp_b.payload_len));
                    if (got.is_retransmit !== exp_b.is_retransmit)
                        report_mismatch("is_retransmit");
                    if (got.in_flight !== exp_b.in_flight)
                        report_mismatch($sformatf("in_flight %0d exp %0d",
                                                  got.in_flight, exp_b.in_flight));
                    if (got.retransmit_count !== exp_b.retransmit_count)
                        report_mismatch("retransmit_count");
                    if (got.last !== exp_b.last) report_mismatch("last");
                end
                gap_draw = $urandom_range(0, 13);
                out_gap <= gap_draw;
                out_ch.ready <= (gap_draw == 0);
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ch.ready <= (out_gap == 1);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (pending_cmds.size() == 0 && expected_segs.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        in_beat_t c;
        int ph;
        n_errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ISN;
        cfg_data = '0;
        reset_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: SYN only, query, ticks, ack, full window, FIN, errors
        c = mk_cmd(CMD_QUERY); c.stream_error = 0; enqueue(c);
        c = mk_cmd(CMD_TICK); c.elapsed_ms = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_TICK); c.elapsed_ms = 0; enqueue(c);
        c = mk_cmd(CMD_TICK); c.elapsed_ms = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_ACK); c.ack_present = 0; c.peer_window = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_ACK); c.ack_present = 1; c.ack_number = 32'd1;
        c.peer_window = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_TICK); c.elapsed_ms = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_ACK); c.ack_present = 1; c.ack_number = 32'hFFFF_FFF0;
        c.peer_window = 0; enqueue(c);
        c = mk_cmd(CMD_TICK); c.elapsed_ms = 16'hFFFF; enqueue(c);
        c = mk_cmd(CMD_ACK); c.ack_present = 1; c.ack_number = 32'd65536;
        c.peer_window = 16'd3000; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'd5; c.stream_error = 1; enqueue(c);
        c = mk_cmd(CMD_QUERY); c.stream_error = 1; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'd0; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'd100; c.stream_closed = 1; enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'd100; c.stream_closed = 1; enqueue(c);
        c = mk_cmd(CMD_ACK); c.ack_present = 1; c.ack_number = 32'd65537 + 100 + 1;
        c.peer_window = 16'd1; c.peer_reset = 1; enqueue(c);
        c = mk_cmd(CMD_QUERY); enqueue(c);
        c = mk_cmd(CMD_PUSH); c.bytes_ready = 16'd10; enqueue(c);
        wait_drain();

        // phases under different settings, each continuing the same stream without a reset;
        // ISN and RTO extremes
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_ISN, 32'hFFFF_FFFF); write_cfg(CFG_RTO, 32'd1); end
                1: begin write_cfg(CFG_ISN, 32'd0); write_cfg(CFG_RTO, 32'd65535); end
                2: begin write_cfg(CFG_ISN, $urandom); write_cfg(CFG_RTO, 32'd300); end
                3: begin write_cfg(CFG_ISN, 32'h8000_0000); write_cfg(CFG_RTO, 32'd1000); end
                default: begin write_cfg(CFG_ISN, $urandom);
                               write_cfg(CFG_RTO, $urandom_range(1, 65535)); end
            endcase
            random_phase(58);
            wait_drain();
        end

        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/tsw_pkg.sv
design/tsw_if.sv
design/tsw_ram.sv
design/tsw_datapath.sv
design/tsw_ctrl.sv
design/tcp_sender_window_retransmit.sv
dv/testbench.sv
